[hw/rtl/cau_pkg.sv]
// Shared types and codes for the complex arithmetic unit.
package cau_pkg;

   localparam logic [1:0] ACT_ADD = 2'd0;
   localparam logic [1:0] ACT_SUB = 2'd1;
   localparam logic [1:0] ACT_MUL = 2'd2;
   localparam logic [1:0] ACT_DIV = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OVF  = 2'd1;
   localparam logic [1:0] ST_DIV0 = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] a_re;
      logic signed [31:0] a_im;
      logic signed [31:0] b_re;
      logic signed [31:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_re;
      logic signed [31:0] res_im;
      logic [1:0]         status;
   } rsp_type;

   // classified item passed from front to back
   typedef struct packed {
      logic [1:0]         action;
      logic               div_zero;
      logic signed [31:0] a_re;
      logic signed [31:0] a_im;
      logic signed [31:0] b_re;
      logic signed [31:0] b_im;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } push_type;

endpackage

[hw/rtl/cau_front.sv]
// Front end: takes items, trims operands to WIDTH bits and flags zero divisors.
module cau_front import cau_pkg::*; #(
   parameter int WIDTH = 32
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  req_type  req_item,
   input  logic     q_full,
   output push_type q_push
);

   logic    front_v_ff, front_v_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept;
   logic    push;

   assign push   = front_v_ff && !q_full;
   assign busy   = reset || (front_v_ff && !push);
   assign accept = start && !busy;

   always_comb begin
      cmd_in.action   = req_item.action;
      cmd_in.a_re     = 32'($signed(req_item.a_re[WIDTH-1:0]));
      cmd_in.a_im     = 32'($signed(req_item.a_im[WIDTH-1:0]));
      cmd_in.b_re     = 32'($signed(req_item.b_re[WIDTH-1:0]));
      cmd_in.b_im     = 32'($signed(req_item.b_im[WIDTH-1:0]));
      cmd_in.div_zero = (req_item.b_re[WIDTH-1:0] == '0) && (req_item.b_im[WIDTH-1:0] == '0);
   end

   always_comb begin
      front_v_in = front_v_ff;
      if (accept) begin
         front_v_in = 1'b1;
      end else if (push) begin
         front_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_v_ff <= 1'b0;
      end else begin
         front_v_ff <= front_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

   assign q_push.push = push;
   assign q_push.cmd  = cmd_ff;

endmodule

[hw/rtl/cau_queue.sv]
// Two-entry queue between front and back.
module cau_queue import cau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type q_push,
   output logic     q_full,
   output logic     pop_valid,
   output cmd_type  pop_cmd
);

   cmd_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign q_full    = (count_ff == 2'd2);
   assign pop       = (count_ff != 2'd0);   // back end never stalls
   assign pop_valid = pop;
   assign pop_cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ q_push.push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(q_push.push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.push) begin
         mem_ff[wr_ptr_ff] <= q_push.cmd;
      end
   end

endmodule

[hw/rtl/cau_back.sv]
// Back end: products, sums, saturation and a pipelined restoring divider.
module cau_back import cau_pkg::*; #(
   parameter int WIDTH     = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    pop_valid,
   input  cmd_type pop_cmd,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   localparam int MW = 2 * WIDTH;
   localparam int PW = 2 * WIDTH + 2;
   localparam int RW = 3 * WIDTH + FRAC_BITS + 1;
   localparam logic [63:0] MaxPos = (64'd1 << (WIDTH - 1)) - 64'd1;
   localparam logic [63:0] MaxNeg = 64'd1 << (WIDTH - 1);
   localparam logic [WIDTH-1:0] SatHi = {1'b0, {(WIDTH-1){1'b1}}};
   localparam logic [WIDTH-1:0] SatLo = {1'b1, {(WIDTH-1){1'b0}}};

   typedef struct packed {
      logic [1:0]       act;
      logic             dz;
      logic [WIDTH-1:0] fx_re;
      logic [WIDTH-1:0] fx_im;
      logic [1:0]       fx_st;
      logic             neg_re;
      logic             neg_im;
      logic             qo_re;
      logic             qo_im;
      logic [RW-1:0]    r_re;
      logic [RW-1:0]    r_im;
      logic [MW-1:0]    den;
      logic [WIDTH-1:0] q_re;
      logic [WIDTH-1:0] q_im;
   } dv_type;

   // stage 0: products and add/sub
   logic signed [WIDTH-1:0] op_a, op_b, op_c, op_d;
   logic signed [MW-1:0]    ac_in, bd_in, ad_in, bc_in, cc_in, dd_in;
   logic signed [WIDTH:0]   as_re_in, as_im_in;
   logic                    s0_v_ff;
   logic [1:0]              s0_act_ff;
   logic                    s0_dz_ff;
   logic signed [MW-1:0]    s0_ac_ff, s0_bd_ff, s0_ad_ff, s0_bc_ff, s0_cc_ff, s0_dd_ff;
   logic signed [WIDTH:0]   s0_as_re_ff, s0_as_im_ff;

   assign op_a = pop_cmd.a_re[WIDTH-1:0];
   assign op_b = pop_cmd.a_im[WIDTH-1:0];
   assign op_c = pop_cmd.b_re[WIDTH-1:0];
   assign op_d = pop_cmd.b_im[WIDTH-1:0];
   assign ac_in = op_a * op_c;
   assign bd_in = op_b * op_d;
   assign ad_in = op_a * op_d;
   assign bc_in = op_b * op_c;
   assign cc_in = op_c * op_c;
   assign dd_in = op_d * op_d;
   assign as_re_in = (pop_cmd.action == ACT_SUB) ? (op_a - op_c) : (op_a + op_c);
   assign as_im_in = (pop_cmd.action == ACT_SUB) ? (op_b - op_d) : (op_b + op_d);

   always_ff @(posedge clock) begin
      s0_act_ff   <= pop_cmd.action;
      s0_dz_ff    <= pop_cmd.div_zero;
      s0_ac_ff    <= ac_in;
      s0_bd_ff    <= bd_in;
      s0_ad_ff    <= ad_in;
      s0_bc_ff    <= bc_in;
      s0_cc_ff    <= cc_in;
      s0_dd_ff    <= dd_in;
      s0_as_re_ff <= as_re_in;
      s0_as_im_ff <= as_im_in;
   end

   // stage 1: product sums and divisor
   logic signed [PW-1:0]  num_re_in, num_im_in;
   logic [MW-1:0]         den_in;
   logic                  s1_v_ff;
   logic [1:0]            s1_act_ff;
   logic                  s1_dz_ff;
   logic signed [PW-1:0]  s1_num_re_ff, s1_num_im_ff;
   logic [MW-1:0]         s1_den_ff;
   logic signed [WIDTH:0] s1_as_re_ff, s1_as_im_ff;

   always_comb begin
      if (s0_act_ff == ACT_DIV) begin
         num_re_in = PW'(s0_ac_ff) + PW'(s0_bd_ff);
         num_im_in = PW'(s0_bc_ff) - PW'(s0_ad_ff);
      end else begin
         num_re_in = PW'(s0_ac_ff) - PW'(s0_bd_ff);
         num_im_in = PW'(s0_ad_ff) + PW'(s0_bc_ff);
      end
      den_in = MW'($unsigned(s0_cc_ff)) + MW'($unsigned(s0_dd_ff));
   end

   always_ff @(posedge clock) begin
      s1_act_ff    <= s0_act_ff;
      s1_dz_ff     <= s0_dz_ff;
      s1_num_re_ff <= num_re_in;
      s1_num_im_ff <= num_im_in;
      s1_den_ff    <= den_in;
      s1_as_re_ff  <= s0_as_re_ff;
      s1_as_im_ff  <= s0_as_im_ff;
   end

   // stage 2: sign and magnitude
   logic                  s2_v_ff;
   logic [1:0]            s2_act_ff;
   logic                  s2_dz_ff;
   logic                  s2_neg_re_ff, s2_neg_im_ff;
   logic [MW-1:0]         s2_mag_re_ff, s2_mag_im_ff;
   logic [MW-1:0]         s2_den_ff;
   logic signed [WIDTH:0] s2_as_re_ff, s2_as_im_ff;
   logic signed [PW-1:0]  neg_num_re, neg_num_im;

   assign neg_num_re = -s1_num_re_ff;
   assign neg_num_im = -s1_num_im_ff;

   always_ff @(posedge clock) begin
      s2_act_ff    <= s1_act_ff;
      s2_dz_ff     <= s1_dz_ff;
      s2_neg_re_ff <= s1_num_re_ff[PW-1];
      s2_neg_im_ff <= s1_num_im_ff[PW-1];
      s2_mag_re_ff <= s1_num_re_ff[PW-1] ? MW'(neg_num_re) : MW'(s1_num_re_ff);
      s2_mag_im_ff <= s1_num_im_ff[PW-1] ? MW'(neg_num_im) : MW'(s1_num_im_ff);
      s2_den_ff    <= s1_den_ff;
      s2_as_re_ff  <= s1_as_re_ff;
      s2_as_im_ff  <= s1_as_im_ff;
   end

   // stage 3: saturate add/sub/mul, set up the divider
   logic [MW-1:0]    m_re, m_im;
   logic             mo_re, mo_im, ao_re, ao_im;
   logic [WIDTH-1:0] mv_re, mv_im, av_re, av_im;
   logic [RW-1:0]    n_re, n_im, dlim;
   dv_type           dv_in;

   always_comb begin
      m_re  = s2_mag_re_ff >> FRAC_BITS;
      m_im  = s2_mag_im_ff >> FRAC_BITS;
      mo_re = s2_neg_re_ff ? (m_re > MW'(MaxNeg)) : (m_re > MW'(MaxPos));
      mo_im = s2_neg_im_ff ? (m_im > MW'(MaxNeg)) : (m_im > MW'(MaxPos));
      mv_re = mo_re ? (s2_neg_re_ff ? SatLo : SatHi)
                    : (s2_neg_re_ff ? -WIDTH'(m_re) : WIDTH'(m_re));
      mv_im = mo_im ? (s2_neg_im_ff ? SatLo : SatHi)
                    : (s2_neg_im_ff ? -WIDTH'(m_im) : WIDTH'(m_im));
      ao_re = s2_as_re_ff[WIDTH] != s2_as_re_ff[WIDTH-1];
      ao_im = s2_as_im_ff[WIDTH] != s2_as_im_ff[WIDTH-1];
      av_re = ao_re ? (s2_as_re_ff[WIDTH] ? SatLo : SatHi) : s2_as_re_ff[WIDTH-1:0];
      av_im = ao_im ? (s2_as_im_ff[WIDTH] ? SatLo : SatHi) : s2_as_im_ff[WIDTH-1:0];
      n_re  = RW'(s2_mag_re_ff) << FRAC_BITS;
      n_im  = RW'(s2_mag_im_ff) << FRAC_BITS;
      dlim  = RW'(s2_den_ff) << WIDTH;

      dv_in.act    = s2_act_ff;
      dv_in.dz     = s2_dz_ff;
      dv_in.neg_re = s2_neg_re_ff;
      dv_in.neg_im = s2_neg_im_ff;
      dv_in.qo_re  = n_re >= dlim;
      dv_in.qo_im  = n_im >= dlim;
      dv_in.r_re   = n_re;
      dv_in.r_im   = n_im;
      dv_in.den    = s2_den_ff;
      dv_in.q_re   = '0;
      dv_in.q_im   = '0;
      case (s2_act_ff)
         ACT_MUL: begin
            dv_in.fx_re = mv_re;
            dv_in.fx_im = mv_im;
            dv_in.fx_st = (mo_re || mo_im) ? ST_OVF : ST_OK;
         end
         ACT_ADD, ACT_SUB: begin
            dv_in.fx_re = av_re;
            dv_in.fx_im = av_im;
            dv_in.fx_st = (ao_re || ao_im) ? ST_OVF : ST_OK;
         end
         default: begin
            dv_in.fx_re = '0;
            dv_in.fx_im = '0;
            dv_in.fx_st = ST_OK;
         end
      endcase
   end

   // divider: one quotient bit per stage, MSB first
   dv_type           dv_ff [WIDTH+1];
   logic [WIDTH:0]   dv_v_ff;

   function automatic dv_type div_step(dv_type s, int j);
      dv_type        t;
      logic [RW-1:0] dsh;
      logic          ge_re, ge_im;
      t     = s;
      dsh   = RW'(s.den) << j;
      ge_re = s.r_re >= dsh;
      ge_im = s.r_im >= dsh;
      t.r_re = ge_re ? (s.r_re - dsh) : s.r_re;
      t.r_im = ge_im ? (s.r_im - dsh) : s.r_im;
      t.q_re = {s.q_re[WIDTH-2:0], ge_re};
      t.q_im = {s.q_im[WIDTH-2:0], ge_im};
      return t;
   endfunction

   always_ff @(posedge clock) begin
      dv_ff[0] <= dv_in;
      for (int k = 0; k < WIDTH; k++) begin
         dv_ff[k+1] <= div_step(dv_ff[k], WIDTH - 1 - k);
      end
   end

   // output stage
   dv_type           fin;
   logic [WIDTH:0]   qm_re, qm_im;
   logic             qv_re, qv_im;
   logic [WIDTH-1:0] dval_re, dval_im;
   rsp_type          rsp_in;
   logic             rsp_v_ff;
   rsp_type          rsp_ff;

   always_comb begin
      fin     = dv_ff[WIDTH];
      qm_re   = fin.qo_re ? ((WIDTH+1)'(1) << WIDTH) : {1'b0, fin.q_re};
      qm_im   = fin.qo_im ? ((WIDTH+1)'(1) << WIDTH) : {1'b0, fin.q_im};
      qv_re   = fin.neg_re ? (qm_re > (WIDTH+1)'(MaxNeg)) : (qm_re > (WIDTH+1)'(MaxPos));
      qv_im   = fin.neg_im ? (qm_im > (WIDTH+1)'(MaxNeg)) : (qm_im > (WIDTH+1)'(MaxPos));
      dval_re = qv_re ? (fin.neg_re ? SatLo : SatHi)
                      : (fin.neg_re ? -WIDTH'(qm_re) : WIDTH'(qm_re));
      dval_im = qv_im ? (fin.neg_im ? SatLo : SatHi)
                      : (fin.neg_im ? -WIDTH'(qm_im) : WIDTH'(qm_im));
      if (fin.act != ACT_DIV) begin
         rsp_in.res_re = 32'($signed(fin.fx_re));
         rsp_in.res_im = 32'($signed(fin.fx_im));
         rsp_in.status = fin.fx_st;
      end else if (fin.dz) begin
         rsp_in.res_re = '0;
         rsp_in.res_im = '0;
         rsp_in.status = ST_DIV0;
      end else begin
         rsp_in.res_re = 32'($signed(dval_re));
         rsp_in.res_im = 32'($signed(dval_im));
         rsp_in.status = (qv_re || qv_im) ? ST_OVF : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff  <= 1'b0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         dv_v_ff  <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         s0_v_ff  <= pop_valid;
         s1_v_ff  <= s0_v_ff;
         s2_v_ff  <= s1_v_ff;
         dv_v_ff  <= {dv_v_ff[WIDTH-1:0], s2_v_ff};
         rsp_v_ff <= dv_v_ff[WIDTH];
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_item  = rsp_ff;

endmodule

[hw/rtl/complex_arith_unit_core.sv]
// Top level of the complex arithmetic unit (add, subtract, multiply, divide).
//
//  channel   ports                      handshake
//  --------  -------------------------  ---------------------------------------
//  request   start, busy, req_item      item taken at edge with start & !busy
//  response  rsp_valid, rsp_item        one-cycle strobe, receiver cannot stall
//
// Cycles: one item per cycle sustained, every operation. The path from the
//   accepting edge to the edge that takes the result runs through the
//   restoring divider (one quotient bit per stage, WIDTH stages).
// Reset: synchronous, active high; clears all valid bits, busy is high during it.
// Stalls: the back end never waits, so the two-entry queue never fills and
//   busy stays low outside reset.
module complex_arith_unit_core import cau_pkg::*; #(
   parameter int WIDTH     = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   push_type q_push;
   logic     q_full;
   logic     pop_valid;
   cmd_type  pop_cmd;

   // front: takes and classifies items
   cau_front #(.WIDTH(WIDTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .q_full   (q_full),
      .q_push   (q_push)
   );

   // decoupling queue
   cau_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .q_push    (q_push),
      .q_full    (q_full),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd)
   );

   // back: arithmetic pipeline
   cau_back #(.WIDTH(WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

[hw/rtl/cau_checker.sv]
// Port-level checks for the complex arithmetic unit, bound to the top level.
module cau_checker import cau_pkg::*; #(
   parameter int WIDTH = 32
) (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_item,
   input logic    rsp_valid,
   input rsp_type rsp_item
);

   localparam int Latency = WIDTH + 7;

   logic accept;
   assign accept = start && !busy;

   // fixed latency, both directions
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##Latency rsp_valid)
      else $error("accepted item gave no result");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, Latency))
      else $error("result without an accepted item");

   // zero divisor reports status and zero result
   a_div0: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.action == ACT_DIV && req_item.b_re[WIDTH-1:0] == '0
       && req_item.b_im[WIDTH-1:0] == '0)
      |-> ##Latency (rsp_item.status == ST_DIV0 && rsp_item.res_re == '0
                     && rsp_item.res_im == '0))
      else $error("zero divisor not reported");

   // results stay inside the signed WIDTH-bit range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_item.res_re[31:WIDTH-1] == '0 || rsp_item.res_re[31:WIDTH-1] == '1)
                  && (rsp_item.res_im[31:WIDTH-1] == '0 || rsp_item.res_im[31:WIDTH-1] == '1)))
      else $error("result not sign-extended");

   // first cycle out of reset shows no strobe
   a_reset: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

endmodule

bind complex_arith_unit_core cau_checker #(.WIDTH(WIDTH)) u_cau_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

[sim/tb_complex_arith_unit_core.sv]
// Self-checking testbench for the complex arithmetic unit core.
`timescale 1ns / 1ps

module tb_complex_arith_unit_core;
   import cau_pkg::*;

   localparam int WIDTH      = 32;
   localparam int FRAC_BITS  = 16;
   localparam int LATENCY    = WIDTH + 7;
   localparam int N_RANDOM   = 800;
   localparam int DRAIN_AT   = 400;      // sender holds here until all results are back
   localparam int CYCLE_CAP  = 200000;
   localparam longint QCAP   = 64'd1 << 40;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;

   req_type pending_q[$];     // items not yet offered
   rsp_type result_q[$];      // predicted results, oldest first
   int      err_count   = 0;
   int      issued      = 0;
   int      checked     = 0;
   int      cycle_count = 0;
   int      gap_left    = 0;
   int      op_count[4] = '{0, 0, 0, 0};
   int      status_seen[3] = '{0, 0, 0};

   complex_arith_unit_core #(.WIDTH(WIDTH), .FRAC_BITS(FRAC_BITS)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---- predictor ------------------------------------------------------------

   // clamp a sign/magnitude value to the signed WIDTH-bit range
   function automatic logic [31:0] clamp_mag(logic [63:0] mag, bit neg, inout bit ovf);
      logic [63:0] maxpos;
      logic [63:0] maxneg;
      maxpos = (64'd1 << (WIDTH - 1)) - 64'd1;
      maxneg = 64'd1 << (WIDTH - 1);
      if (!neg) begin
         if (mag > maxpos) begin
            ovf = 1'b1;
            mag = maxpos;
         end
         return mag[31:0];
      end
      if (mag > maxneg) begin
         ovf = 1'b1;
         mag = maxneg;
      end
      return 32'(64'd0 - mag);
   endfunction

   // two's complement pattern in (-2^63, 2^63] -> sign and magnitude
   function automatic logic [63:0] split_mag(logic [63:0] s, output bit neg);
      neg = s[63] && (s != (64'd1 << 63));
      return neg ? (64'd0 - s) : s;
   endfunction

   // floor(num * 2^FRAC_BITS / den), capped at QCAP
   function automatic logic [63:0] frac_divide(logic [63:0] num, logic [63:0] den);
      logic [63:0] q;
      logic [63:0] r;
      bit          carry;
      bit          qbit;
      q = num / den;
      r = num % den;
      if (q > QCAP) q = QCAP;
      for (int i = 0; i < FRAC_BITS; i++) begin
         carry = r[63];
         qbit  = 1'b0;
         r     = r << 1;
         if (carry || r >= den) begin
            r    = r - den;
            qbit = 1'b1;
         end
         q = (q >= QCAP) ? QCAP : ((q << 1) | 64'(qbit));
      end
      return q;
   endfunction

   function automatic rsp_type complex_result(req_type r);
      rsp_type     res;
      logic [63:0] a, b, c, d, den, mr, mi;
      bit          nr, ni, ovf;
      a   = 64'(r.a_re);
      b   = 64'(r.a_im);
      c   = 64'(r.b_re);
      d   = 64'(r.b_im);
      ovf = 1'b0;
      res = '0;
      res.status = ST_OK;
      case (r.action)
         ACT_ADD: begin
            mr = split_mag(a + c, nr);
            mi = split_mag(b + d, ni);
            res.res_re = clamp_mag(mr, nr, ovf);
            res.res_im = clamp_mag(mi, ni, ovf);
         end
         ACT_SUB: begin
            mr = split_mag(a - c, nr);
            mi = split_mag(b - d, ni);
            res.res_re = clamp_mag(mr, nr, ovf);
            res.res_im = clamp_mag(mi, ni, ovf);
         end
         ACT_MUL: begin
            mr = split_mag(a * c - b * d, nr);
            mi = split_mag(a * d + b * c, ni);
            res.res_re = clamp_mag(mr >> FRAC_BITS, nr, ovf);
            res.res_im = clamp_mag(mi >> FRAC_BITS, ni, ovf);
         end
         default: begin
            den = c * c + d * d;
            if (den == 64'd0) begin
               res.status = ST_DIV0;
            end else begin
               mr = split_mag(a * c + b * d, nr);
               mi = split_mag(b * c - a * d, ni);
               res.res_re = clamp_mag(frac_divide(mr, den), nr, ovf);
               res.res_im = clamp_mag(frac_divide(mi, den), ni, ovf);
            end
         end
      endcase
      if (res.status == ST_OK && ovf) res.status = ST_OVF;
      return res;
   endfunction

   // ---- stimulus helpers -------------------------------------------------------

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 5))
         0, 1:    return $urandom();                                  // full range
         2, 3:    return 32'($signed($urandom_range(0, 32'h3F_FFFF)) - 32'sh1F_FFFF);
         4:       return 32'($signed($urandom_range(0, 32'h1FFF)) - 32'sh0FFF);
         default: begin
            case ($urandom_range(0, 4))
               0:       return 32'h8000_0000;
               1:       return 32'h7FFF_FFFF;
               2:       return 32'h0000_0000;
               3:       return 32'h0001_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   function automatic req_type make_item(logic [1:0] act, logic [31:0] ar, logic [31:0] ai,
                                         logic [31:0] br, logic [31:0] bi);
      req_type r;
      r.action = act;
      r.a_re   = ar;
      r.a_im   = ai;
      r.b_re   = br;
      r.b_im   = bi;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH item %0d %s: got %h expected %h", checked, what, got, want);
      err_count++;
   endtask

   // ---- driver: one item per handshake, random gaps, one drain pause ----------

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         // hold the offered item until it is taken
      end else begin
         if (start) begin
            result_q.push_back(complex_result(req_item));
            op_count[req_item.action]++;
            issued++;
         end
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start    <= 1'b0;
         end else if (issued == DRAIN_AT && result_q.size() != 0) begin
            start <= 1'b0;   // let the pipe empty once
         end else if (pending_q.size() != 0) begin
            req_item <= pending_q.pop_front();
            start    <= 1'b1;
            // stretches of back-to-back items alternate with gappy ones
            gap_left <= ((issued / 64) % 2 == 0) ? 0 : $urandom_range(0, 15);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ---- monitor: compare every strobed result with the oldest prediction -----

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (result_q.size() == 0) begin
            report_mismatch("unexpected result, res_re", rsp_item.res_re, 32'h0);
         end else begin
            want = result_q.pop_front();
            if (rsp_item.res_re !== want.res_re)
               report_mismatch("res_re", rsp_item.res_re, want.res_re);
            if (rsp_item.res_im !== want.res_im)
               report_mismatch("res_im", rsp_item.res_im, want.res_im);
            if (rsp_item.status !== want.status)
               report_mismatch("status", 32'(rsp_item.status), 32'(want.status));
            if (want.status <= ST_DIV0) status_seen[want.status]++;
         end
         checked++;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count, result_q.size());
         $display("tb_complex_arith_unit_core: done, errors");
         $finish;
      end
   end

   // ---- test sequence --------------------------------------------------------

   initial begin
      logic [1:0] act;
      // directed: extremes per operation, zero divisor, saturation corners
      for (int k = 0; k < 4; k++) begin
         act = 2'(k);
         pending_q.push_back(make_item(act, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                       32'h7FFF_FFFF, 32'h7FFF_FFFF));
         pending_q.push_back(make_item(act, 32'h8000_0000, 32'h8000_0000,
                                       32'h8000_0000, 32'h8000_0000));
         pending_q.push_back(make_item(act, 32'h7FFF_FFFF, 32'h8000_0000,
                                       32'h8000_0000, 32'h7FFF_FFFF));
         pending_q.push_back(make_item(act, 32'h0001_8000, 32'hFFFE_8000,
                                       32'h0002_0000, 32'hFFFF_0000));
      end
      pending_q.push_back(make_item(ACT_DIV, 32'h0003_0000, 32'h1234_5678, 32'h0, 32'h0));
      pending_q.push_back(make_item(ACT_DIV, 32'h0, 32'h0, 32'h0, 32'h0));
      pending_q.push_back(make_item(ACT_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h0));
      pending_q.push_back(make_item(ACT_DIV, 32'h0001_0000, 32'h0, 32'h0, 32'hFFFF_FFFF));
      pending_q.push_back(make_item(ACT_DIV, 32'h0000_0001, 32'hFFFF_FFFF,
                                    32'h7FFF_FFFF, 32'h8000_0000));
      pending_q.push_back(make_item(ACT_MUL, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF));
      pending_q.push_back(make_item(ACT_SUB, 32'h0, 32'h8000_0000, 32'h0, 32'h8000_0000));
      pending_q.push_back(make_item(ACT_ADD, 32'hFFFF_FFFF, 32'h1, 32'h1, 32'hFFFF_FFFF));

      for (int k = 0; k < N_RANDOM; k++)
         pending_q.push_back(make_item(2'($urandom_range(0, 3)), pick_operand(),
                                       pick_operand(), pick_operand(), pick_operand()));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || start || result_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      $display("covered %0d items: add %0d, sub %0d, mul %0d, div %0d", issued,
               op_count[ACT_ADD], op_count[ACT_SUB], op_count[ACT_MUL], op_count[ACT_DIV]);
      $display("results ok %0d, saturated %0d, zero divisor %0d, mismatches %0d",
               status_seen[ST_OK], status_seen[ST_OVF], status_seen[ST_DIV0], err_count);
      if (err_count == 0 && result_q.size() == 0) begin
         $display("tb_complex_arith_unit_core: done, clean");
      end else begin
         $display("tb_complex_arith_unit_core: done, errors");
      end
      $finish;
   end

endmodule
